[design/wsd_pkg.sv]
package wsd_pkg;

    localparam int LEN_W      = 64;
    localparam int FLEN_W     = 63;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 63;

    localparam logic [FLEN_W-1:0] MAX_LEN_RESET = 63'd65535;
    localparam logic              REQ_MASK_RESET = 1'b1;
    localparam logic [FLEN_W-1:0] LEN_SATURATED = {FLEN_W{1'b1}};

    localparam logic [6:0] LEN7_EXT16 = 7'd126;
    localparam logic [6:0] LEN7_EXT64 = 7'd127;

    // remaining extended-length bytes after the first one, and key bytes after the first
    localparam logic [2:0] EXT16_COUNT = 3'd1;
    localparam logic [2:0] EXT64_COUNT = 3'd7;
    localparam logic [2:0] KEY_COUNT   = 3'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LEN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REQ_MASK = 2'd1;

    localparam logic KIND_HEADER  = 1'b0;
    localparam logic KIND_PAYLOAD = 1'b1;

    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_TOO_LONG = 2'd1;
    localparam logic [1:0] ERR_UNMASKED = 2'd2;

    typedef enum logic [2:0] {
        PH_FIRST   = 3'd0,
        PH_LEN     = 3'd1,
        PH_EXT     = 3'd2,
        PH_KEY     = 3'd3,
        PH_PAYLOAD = 3'd4
    } t_phase;

    typedef struct packed {
        logic              item_kind;
        logic              fin_bit;
        logic [2:0]        rsv_bits;
        logic [3:0]        frame_opcode;
        logic              mask_bit;
        logic [FLEN_W-1:0] frame_length;
        logic [7:0]        data_byte;
        logic              last_of_frame;
        logic [1:0]        error_code;
    } t_result;

endpackage

[design/wsd_parser.sv]
module wsd_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [7:0]                    i_byte,
    input  logic [wsd_pkg::FLEN_W-1:0]    i_max_len,
    input  logic                          i_req_mask,
    output logic                          o_res_valid,
    output wsd_pkg::t_result              o_res
);

    wsd_pkg::t_phase                 r_phase, n_phase;
    logic [7:0]                      r_first, n_first;
    logic                            r_mask, n_mask;
    logic [wsd_pkg::LEN_W-1:0]       r_len, n_len;
    logic [2:0]                      r_cnt, n_cnt;
    logic [31:0]                     r_key, n_key;
    logic [wsd_pkg::LEN_W-1:0]       r_rem, n_rem;
    logic [1:0]                      r_kidx, n_kidx;
    logic                            r_disc, n_disc;

    logic                            after_len;
    logic                            hdr_done;
    logic [wsd_pkg::LEN_W-1:0]       hdr_len;
    logic [wsd_pkg::LEN_W-1:0]       ext_len;
    logic                            pay_last;
    logic [1:0]                      hdr_err;
    logic [7:0]                      key_byte;

    assign ext_len  = {r_len[wsd_pkg::LEN_W-9:0], i_byte};
    assign pay_last = (r_rem[wsd_pkg::LEN_W-1:1] == '0);
    // key byte 0 sits in the top byte of the shifted-in key
    assign key_byte = r_key[{~r_kidx, 3'b000} +: 8];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= wsd_pkg::PH_FIRST;
            r_first <= '0;
            r_mask  <= 1'b0;
            r_len   <= '0;
            r_cnt   <= '0;
            r_key   <= '0;
            r_rem   <= '0;
            r_kidx  <= '0;
            r_disc  <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_first <= n_first;
            r_mask  <= n_mask;
            r_len   <= n_len;
            r_cnt   <= n_cnt;
            r_key   <= n_key;
            r_rem   <= n_rem;
            r_kidx  <= n_kidx;
            r_disc  <= n_disc;
        end
    end

    always_comb begin
        n_phase     = r_phase;
        n_first     = r_first;
        n_mask      = r_mask;
        n_len       = r_len;
        n_cnt       = r_cnt;
        n_key       = r_key;
        n_rem       = r_rem;
        n_kidx      = r_kidx;
        n_disc      = r_disc;
        after_len   = 1'b0;
        hdr_done    = 1'b0;
        hdr_len     = r_len;
        hdr_err     = wsd_pkg::ERR_NONE;
        o_res_valid = 1'b0;
        o_res       = '0;

        if (i_accept) begin
            unique case (r_phase)
                wsd_pkg::PH_LEN: begin
                    n_mask = i_byte[7];
                    n_len  = '0;
                    if (i_byte[6:0] == wsd_pkg::LEN7_EXT16) begin
                        n_cnt   = wsd_pkg::EXT16_COUNT;
                        n_phase = wsd_pkg::PH_EXT;
                    end else if (i_byte[6:0] == wsd_pkg::LEN7_EXT64) begin
                        n_cnt   = wsd_pkg::EXT64_COUNT;
                        n_phase = wsd_pkg::PH_EXT;
                    end else begin
                        n_len     = {{(wsd_pkg::LEN_W-7){1'b0}}, i_byte[6:0]};
                        hdr_len   = n_len;
                        after_len = 1'b1;
                    end
                end
                wsd_pkg::PH_EXT: begin
                    n_len = ext_len;
                    if (r_cnt == '0) begin
                        hdr_len   = ext_len;
                        after_len = 1'b1;
                    end else begin
                        n_cnt = r_cnt - 3'd1;
                    end
                end
                wsd_pkg::PH_KEY: begin
                    n_key = {r_key[23:0], i_byte};
                    if (r_cnt == '0) begin
                        hdr_done = 1'b1;
                    end else begin
                        n_cnt = r_cnt - 3'd1;
                    end
                end
                wsd_pkg::PH_PAYLOAD: begin
                    if (pay_last) begin
                        n_rem   = '0;
                        n_phase = wsd_pkg::PH_FIRST;
                    end else begin
                        n_rem = r_rem - 64'd1;
                    end
                    // payload bytes of dropped frames produce nothing
                    if (!r_disc) begin
                        n_kidx                = r_kidx + 2'd1;
                        o_res_valid           = 1'b1;
                        o_res.item_kind       = wsd_pkg::KIND_PAYLOAD;
                        o_res.data_byte       = r_mask ? (i_byte ^ key_byte) : i_byte;
                        o_res.last_of_frame   = pay_last;
                    end
                end
                default: begin
                    n_first = i_byte;
                    n_mask  = 1'b0;
                    n_phase = wsd_pkg::PH_LEN;
                end
            endcase

            if (after_len) begin
                if (n_mask) begin
                    n_cnt   = wsd_pkg::KEY_COUNT;
                    n_key   = '0;
                    n_phase = wsd_pkg::PH_KEY;
                end else begin
                    hdr_done = 1'b1;
                end
            end

            if (hdr_done) begin
                if (hdr_len > {1'b0, i_max_len}) begin
                    hdr_err = wsd_pkg::ERR_TOO_LONG;
                end else if (!n_mask && i_req_mask) begin
                    hdr_err = wsd_pkg::ERR_UNMASKED;
                end
                n_rem   = hdr_len;
                n_kidx  = '0;
                n_disc  = (hdr_err != wsd_pkg::ERR_NONE);
                n_phase = (hdr_len == '0) ? wsd_pkg::PH_FIRST : wsd_pkg::PH_PAYLOAD;

                o_res_valid         = 1'b1;
                o_res.item_kind     = wsd_pkg::KIND_HEADER;
                o_res.fin_bit       = r_first[7];
                o_res.rsv_bits      = r_first[6:4];
                o_res.frame_opcode  = r_first[3:0];
                o_res.mask_bit      = n_mask;
                o_res.frame_length  = hdr_len[wsd_pkg::LEN_W-1] ? wsd_pkg::LEN_SATURATED
                                                               : hdr_len[wsd_pkg::FLEN_W-1:0];
                o_res.last_of_frame = (hdr_len == '0) || (hdr_err != wsd_pkg::ERR_NONE);
                o_res.error_code    = hdr_err;
            end
        end
    end

endmodule

[design/websocket_frame_deframer.sv]
// Each result is registered (output or skid register) once its final byte is taken.
// Throughput: one byte per cycle unless o_in_stall; a header gives one result, at its end.
// The parser state advances once per accepted byte; while the output register is
// stalled, a skid register takes one more result, and then the input stalls.
// Reset (i_rst_n low, synchronous): parser waits for a first header byte, buffers empty,
// max_payload_len = 65535, require_mask = 1.
module websocket_frame_deframer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic [7:0]                        i_rx_byte,
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic                              o_item_kind,
    output logic                              o_fin_bit,
    output logic [2:0]                        o_rsv_bits,
    output logic [3:0]                        o_frame_opcode,
    output logic                              o_mask_bit,
    output logic [wsd_pkg::FLEN_W-1:0]        o_frame_length,
    output logic [7:0]                        o_data_byte,
    output logic                              o_last_of_frame,
    output logic [1:0]                        o_error_code,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [wsd_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [wsd_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    logic [wsd_pkg::FLEN_W-1:0] r_max_len;
    logic                       r_req_mask;
    logic                       r_out_valid;
    wsd_pkg::t_result           r_out;
    logic                       r_skid_valid;
    wsd_pkg::t_result           r_skid;

    logic                       in_accept;
    logic                       out_pop;
    logic                       res_valid;
    wsd_pkg::t_result           res;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = r_skid_valid;
    assign in_accept   = i_in_valid && !r_skid_valid;
    assign out_pop     = r_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_len  <= wsd_pkg::MAX_LEN_RESET;
            r_req_mask <= wsd_pkg::REQ_MASK_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == wsd_pkg::CFG_MAX_LEN) begin
                r_max_len <= i_cfg_data;
            end else if (i_cfg_index == wsd_pkg::CFG_REQ_MASK) begin
                r_req_mask <= i_cfg_data[0];
            end
        end
    end

    wsd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (in_accept),
        .i_byte      (i_rx_byte),
        .i_max_len   (r_max_len),
        .i_req_mask  (r_req_mask),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    // skid holds a word only while the output register is full and stalled
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (!r_out_valid || out_pop) begin
            r_out_valid  <= r_skid_valid || res_valid;
            r_skid_valid <= 1'b0;
        end else if (res_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || out_pop) begin
            r_out <= r_skid_valid ? r_skid : res;
        end
        if (r_out_valid && !out_pop && res_valid) begin
            r_skid <= res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_item_kind     = r_out.item_kind;
    assign o_fin_bit       = r_out.fin_bit;
    assign o_rsv_bits      = r_out.rsv_bits;
    assign o_frame_opcode  = r_out.frame_opcode;
    assign o_mask_bit      = r_out.mask_bit;
    assign o_frame_length  = r_out.frame_length;
    assign o_data_byte     = r_out.data_byte;
    assign o_last_of_frame = r_out.last_of_frame;
    assign o_error_code    = r_out.error_code;

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid word held with empty output register");

    a_err_ends_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.item_kind == wsd_pkg::KIND_HEADER
         && r_out.error_code != wsd_pkg::ERR_NONE) |-> r_out.last_of_frame)
        else $error("rejected frame header not marked last");

    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.item_kind == wsd_pkg::KIND_PAYLOAD)
        |-> (r_out.error_code == wsd_pkg::ERR_NONE && r_out.frame_length == '0))
        else $error("payload word carries header fields");

    a_no_loss: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_valid && !out_pop) |=> r_skid_valid)
        else $error("stalled skid word dropped");

endmodule
